// File: design/bsfe_pkg.sv
// shared types and constants for the byte stuffed frame encoder
// used by the front, queue, back and top level modules
package bsfe_pkg;

    localparam int unsigned BSFE_QUEUE_DEPTH = 4;

    localparam logic [7:0] FLAG_BYTE = 8'h7E;
    localparam logic [7:0] ESC_BYTE  = 8'h7D;
    localparam logic [7:0] ESC_XOR   = 8'h20;
    localparam logic [7:0] BYTE_MASK = 8'hFF;

    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_PAYLOAD = 1'b1;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_OUTSIDE = 2'd1;
    localparam logic [1:0] ERR_ABANDON = 2'd2;

    typedef enum logic [1:0] {
        JOB_START,
        JOB_DATA,
        JOB_BAD
    } job_kind_t;

    // one classified item: data jobs keep their byte in hdr[7:0]
    typedef struct packed {
        job_kind_t   kind;
        logic [1:0]  err;
        logic [31:0] hdr;
        logic        closing;
        logic [15:0] csum;
    } job_t;

endpackage

// File: design/bsfe_front.sv
// front part: accepts items, keeps frame state and running sum, builds jobs
// depends on bsfe_pkg
module bsfe_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               cmd,
    input  logic [15:0]        frame_command,
    input  logic [15:0]        payload_length,
    input  logic [7:0]         data_byte,
    output logic               push,
    output bsfe_pkg::job_t     push_job,
    input  logic               queue_full
);
    import bsfe_pkg::*;

    logic        frame_open_reg, frame_open_next;
    logic [15:0] bytes_left_reg, bytes_left_next;
    logic [15:0] sum_reg, sum_next;
    logic        accept;
    logic [15:0] hdr_sum;
    logic [15:0] data_sum;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;
    assign push     = accept;

    assign hdr_sum  = {8'd0, frame_command[15:8]} + {8'd0, frame_command[7:0]}
                    + {8'd0, payload_length[15:8]} + {8'd0, payload_length[7:0]};
    assign data_sum = sum_reg + {8'd0, data_byte};

    always_comb
    begin
        frame_open_next  = frame_open_reg;
        bytes_left_next  = bytes_left_reg;
        sum_next         = sum_reg;
        push_job.kind    = JOB_BAD;
        push_job.err     = ERR_OUTSIDE;
        push_job.hdr     = {frame_command, payload_length};
        push_job.closing = 1'b0;
        push_job.csum    = hdr_sum;
        if (cmd == CMD_START)
        begin
            push_job.kind    = JOB_START;
            push_job.err     = frame_open_reg ? ERR_ABANDON : ERR_NONE;
            push_job.closing = (payload_length == 16'd0);
            push_job.csum    = hdr_sum;
            if (payload_length == 16'd0)
            begin
                frame_open_next = 1'b0;
                bytes_left_next = 16'd0;
                sum_next        = 16'd0;
            end
            else
            begin
                frame_open_next = 1'b1;
                bytes_left_next = payload_length;
                sum_next        = hdr_sum;
            end
        end
        else if (frame_open_reg)
        begin
            push_job.kind    = JOB_DATA;
            push_job.err     = ERR_NONE;
            push_job.hdr     = {24'd0, data_byte};
            push_job.closing = (bytes_left_reg == 16'd1);
            push_job.csum    = data_sum;
            if (bytes_left_reg == 16'd1)
            begin
                frame_open_next = 1'b0;
                bytes_left_next = 16'd0;
                sum_next        = 16'd0;
            end
            else
            begin
                bytes_left_next = bytes_left_reg - 16'd1;
                sum_next        = data_sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_open_reg <= 1'b0;
            bytes_left_reg <= 16'd0;
            sum_reg        <= 16'd0;
        end
        else if (accept)
        begin
            frame_open_reg <= frame_open_next;
            bytes_left_reg <= bytes_left_next;
            sum_reg        <= sum_next;
        end
    end

endmodule

// File: design/bsfe_queue.sv
// short job queue between front and back
// depends on bsfe_pkg
module bsfe_queue #(
    parameter int unsigned DEPTH = bsfe_pkg::BSFE_QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  bsfe_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output bsfe_pkg::job_t head_job
);
    import bsfe_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    job_t             slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = slots_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: design/bsfe_back.sv
// back part: walks each job's line bytes, inserts escapes, drives the output register
// depends on bsfe_pkg
module bsfe_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           head_valid,
    input  bsfe_pkg::job_t head_job,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [7:0]     out_byte,
    output logic           last_of_run,
    output logic           frame_end,
    output logic [1:0]     error
);
    import bsfe_pkg::*;

    logic [2:0] idx_reg;
    logic       esc_reg;
    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       end_reg;
    logic [1:0] err_reg;

    logic [2:0] pos;
    logic [7:0] tok_byte;
    logic       tok_stuff;
    logic       tok_end;
    logic       tok_last;
    logic       load;
    logic       adv;
    logic [7:0] emit_byte;

    // data jobs start at the header's last byte slot
    assign pos  = (head_job.kind == JOB_DATA) ? idx_reg + 3'd4 : idx_reg;
    assign load = head_valid && (!valid_reg || out_ready);

    always_comb
    begin
        tok_byte  = 8'd0;
        tok_stuff = 1'b0;
        tok_end   = 1'b0;
        tok_last  = 1'b1;
        if (head_job.kind != JOB_BAD)
        begin
            tok_last = head_job.closing ? (pos == 3'd7) : (pos == 3'd4);
            case (pos)
                3'd0:
                begin
                    tok_byte = FLAG_BYTE;
                end
                3'd1:
                begin
                    tok_byte  = head_job.hdr[31:24];
                    tok_stuff = 1'b1;
                end
                3'd2:
                begin
                    tok_byte  = head_job.hdr[23:16];
                    tok_stuff = 1'b1;
                end
                3'd3:
                begin
                    tok_byte  = head_job.hdr[15:8];
                    tok_stuff = 1'b1;
                end
                3'd4:
                begin
                    tok_byte  = head_job.hdr[7:0];
                    tok_stuff = 1'b1;
                end
                3'd5:
                begin
                    tok_byte  = head_job.csum[15:8];
                    tok_stuff = 1'b1;
                end
                3'd6:
                begin
                    tok_byte  = head_job.csum[7:0];
                    tok_stuff = 1'b1;
                end
                default:
                begin
                    tok_byte = FLAG_BYTE;
                    tok_end  = 1'b1;
                end
            endcase
        end
    end

    always_comb
    begin
        adv       = 1'b1;
        emit_byte = tok_byte & BYTE_MASK;
        if (esc_reg)
        begin
            emit_byte = tok_byte ^ ESC_XOR;
        end
        else if (tok_stuff && (tok_byte == FLAG_BYTE || tok_byte == ESC_BYTE))
        begin
            emit_byte = ESC_BYTE;
            adv       = 1'b0;
        end
    end

    assign pop = load && adv && tok_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 3'd0;
            esc_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                if (adv)
                begin
                    esc_reg <= 1'b0;
                    idx_reg <= tok_last ? 3'd0 : idx_reg + 3'd1;
                end
                else
                begin
                    esc_reg <= 1'b1;
                end
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= emit_byte;
            last_reg <= adv && tok_last;
            end_reg  <= adv && tok_end;
            err_reg  <= head_job.err;
        end
    end

    assign out_valid   = valid_reg;
    assign out_byte    = byte_reg;
    assign last_of_run = last_reg;
    assign frame_end   = end_reg;
    assign error       = err_reg;

endmodule

// File: design/byte_stuffed_frame_encoder.sv
// byte stuffed frame encoder with 16-bit additive checksum
// an item's first line byte passes a queue slot, then the output register
// throughput: one line byte per cycle from the back sequencer while m_axis_tready is
// high; escapes add bytes, and a closing item adds the checksum and end flag
// reset: asynchronous active-low rst_n clears frame state, queue and output valid
// depends on bsfe_pkg, bsfe_front, bsfe_queue, bsfe_back
module byte_stuffed_frame_encoder #(
    parameter int unsigned QUEUE_DEPTH = bsfe_pkg::BSFE_QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [15:0] frame_command, [31:16] payload_length, [39:32] data_byte
    input  logic [39:0] s_axis_tdata,
    // [0] cmd
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] out_byte
    output logic [7:0]  m_axis_tdata,
    output logic        m_axis_tlast,
    // [0] frame_end, [2:1] error
    output logic [2:0]  m_axis_tuser
);
    import bsfe_pkg::*;

    logic push;
    job_t push_job;
    logic queue_full;
    logic pop;
    logic head_valid;
    job_t head_job;
    logic frame_end;
    logic [1:0] error;

    bsfe_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_axis_tvalid),
        .in_ready       (s_axis_tready),
        .cmd            (s_axis_tuser),
        .frame_command  (s_axis_tdata[15:0]),
        .payload_length (s_axis_tdata[31:16]),
        .data_byte      (s_axis_tdata[39:32]),
        .push           (push),
        .push_job       (push_job),
        .queue_full     (queue_full)
    );

    bsfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    bsfe_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_job    (head_job),
        .pop         (pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_byte    (m_axis_tdata),
        .last_of_run (m_axis_tlast),
        .frame_end   (frame_end),
        .error       (error)
    );

    assign m_axis_tuser = {error, frame_end};

endmodule
